// ===== hdl/sdci_pkg.sv =====
package sdci_pkg;

  // sequencer phase codes, as seen on the result beat
  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_CMD0 = 4'd1,
    PH_CMD8 = 4'd2,
    PH_POLL = 4'd3,
    PH_CID  = 4'd4,
    PH_RCA  = 4'd5,
    PH_CSD  = 4'd6,
    PH_SEL  = 4'd7,
    PH_BLK  = 4'd8,
    PH_BUS  = 4'd9,
    PH_DONE = 4'd10,
    PH_ERR  = 4'd11
  } phase_e;

  // expected response type of the issued command
  typedef enum logic [2:0] {
    RK_NONE = 3'd0,
    RK_R1   = 3'd1,
    RK_R1B  = 3'd2,
    RK_R2   = 3'd3,
    RK_R3   = 3'd4,
    RK_R6   = 3'd5,
    RK_R7   = 3'd6
  } resp_kind_e;

  // operation field of an input beat
  localparam logic OP_START   = 1'b0;
  localparam logic OP_OUTCOME = 1'b1;

  // command indexes
  localparam logic [5:0] CMD_GO_IDLE       = 6'd0;
  localparam logic [5:0] CMD_ALL_SEND_CID  = 6'd2;
  localparam logic [5:0] CMD_SEND_RCA      = 6'd3;
  localparam logic [5:0] ACMD_SET_BUS_WIDTH = 6'd6;
  localparam logic [5:0] CMD_SELECT        = 6'd7;
  localparam logic [5:0] CMD_SEND_IF_COND  = 6'd8;
  localparam logic [5:0] CMD_SEND_CSD      = 6'd9;
  localparam logic [5:0] CMD_SET_BLOCKLEN  = 6'd16;
  localparam logic [5:0] ACMD_SD_SEND_OP   = 6'd41;
  localparam logic [5:0] CMD_APP           = 6'd55;

  // command arguments and response fields
  localparam logic [31:0] CMD8_ARG     = 32'h0000_01AA;
  localparam logic [7:0]  CMD8_ECHO    = 8'hAA;
  localparam logic [31:0] ACMD41_HCS   = 32'h4000_0000;
  localparam logic [31:0] ACMD41_VOLT  = 32'h00FF_8000;
  localparam logic [31:0] BLOCKLEN_ARG = 32'd512;
  localparam logic [31:0] BUS4_ARG     = 32'h0000_0002;
  localparam int unsigned OCR_BUSY_BIT = 31;
  localparam int unsigned OCR_CCS_BIT  = 30;

  // configuration register indexes and reset values
  localparam logic CFG_IDX_HOST_FOUR_BIT = 1'b0;
  localparam logic CFG_IDX_POLL_LIMIT    = 1'b1;
  localparam logic [15:0] POLL_LIMIT_RST = 16'd1000;

  typedef struct packed {
    logic        host_four_bit;
    logic [15:0] poll_limit;
  } cfg_t;

  typedef struct packed {
    logic        operation;
    logic        cmd_failed;
    logic [31:0] response_word0;
    logic [31:0] response_word1;
    logic [31:0] response_word2;
  } in_beat_t;

  typedef struct packed {
    logic        issue_cmd;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_argument;
    resp_kind_e  response_kind;
    phase_e      phase;
    logic        high_capacity;
    logic [15:0] card_address;
    logic [32:0] size_blocks;
    logic        bus_four_bit;
    logic        switch_clock;
    logic        init_done;
    logic        init_error;
  } out_beat_t;

endpackage

// ===== hdl/sdci_csd_decode.sv =====
module sdci_csd_decode (
  input  logic        high_capacity_i,
  input  logic [31:0] word1_i,
  input  logic [31:0] word2_i,
  output logic [32:0] blocks_o
);

  logic [7:0]  b5, b6, b7, b8, b9, b10;
  logic [22:0] v2_size;
  logic [12:0] v1_size;
  logic [3:0]  v1_bl;
  logic [2:0]  v1_mult;
  logic [4:0]  v1_shift;
  logic [36:0] v1_bytes;

  assign b5  = word1_i[15:8];
  assign b6  = word1_i[23:16];
  assign b7  = word1_i[31:24];
  assign b8  = word2_i[7:0];
  assign b9  = word2_i[15:8];
  assign b10 = word2_i[23:16];

  // csd v2: (c_size + 1) * 1024 blocks
  assign v2_size = {1'b0, b7[5:0], b8, b9} + 23'd1;

  // csd v1: (c_size + 1) << (size multiplier + 2 + block length exponent) bytes,
  // in 512-byte units
  assign v1_size  = {1'b0, b6[1:0], b7, b8[7:6]} + 13'd1;
  assign v1_bl    = b5[3:0];
  assign v1_mult  = {b9[1:0], b10[7]};
  assign v1_shift = {2'b00, v1_mult} + {1'b0, v1_bl} + 5'd2;
  assign v1_bytes = {24'd0, v1_size} << v1_shift;

  always_comb begin
    if (high_capacity_i) begin
      blocks_o = {v2_size, 10'd0};
    end else begin
      blocks_o = {5'd0, v1_bytes[36:9]};
    end
  end

endmodule

// ===== hdl/sdci_fsm.sv =====
module sdci_fsm (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  sdci_pkg::in_beat_t  beat_i,
  input  sdci_pkg::cfg_t      cfg_i,
  output sdci_pkg::out_beat_t res_o
);

  sdci_pkg::phase_e phase_q, phase_d;
  logic        v2_q, v2_d;
  logic [15:0] poll_cnt_q, poll_cnt_d;
  logic        hc_q, hc_d;
  logic [15:0] rca_q, rca_d;
  logic [32:0] blocks_q, blocks_d;
  logic        four_q, four_d;
  logic        app_q, app_d;

  logic        issue;
  logic [5:0]  idx;
  logic [31:0] arg;
  sdci_pkg::resp_kind_e kind;
  logic        sw;
  logic        fail;
  logic [15:0] poll_inc;
  logic [32:0] csd_blocks;

  sdci_csd_decode u_csd (
    .high_capacity_i (hc_q),
    .word1_i         (beat_i.response_word1),
    .word2_i         (beat_i.response_word2),
    .blocks_o        (csd_blocks)
  );

  assign fail     = beat_i.cmd_failed;
  assign poll_inc = (poll_cnt_q != 16'hFFFF) ? poll_cnt_q + 16'd1 : poll_cnt_q;

  always_comb begin
    phase_d    = phase_q;
    v2_d       = v2_q;
    poll_cnt_d = poll_cnt_q;
    hc_d       = hc_q;
    rca_d      = rca_q;
    blocks_d   = blocks_q;
    four_d     = four_q;
    app_d      = app_q;
    issue      = 1'b0;
    idx        = '0;
    arg        = '0;
    kind       = sdci_pkg::RK_NONE;
    sw         = 1'b0;

    if (beat_i.operation == sdci_pkg::OP_START) begin
      v2_d       = 1'b0;
      poll_cnt_d = '0;
      hc_d       = 1'b0;
      rca_d      = '0;
      blocks_d   = '0;
      four_d     = 1'b0;
      app_d      = 1'b0;
      phase_d    = sdci_pkg::PH_CMD0;
      issue      = 1'b1;
      idx        = sdci_pkg::CMD_GO_IDLE;
    end else begin
      unique case (phase_q)
        sdci_pkg::PH_CMD0: begin
          if (fail) begin
            phase_d = sdci_pkg::PH_ERR;
          end else begin
            phase_d = sdci_pkg::PH_CMD8;
            issue   = 1'b1;
            idx     = sdci_pkg::CMD_SEND_IF_COND;
            arg     = sdci_pkg::CMD8_ARG;
            kind    = sdci_pkg::RK_R7;
          end
        end
        sdci_pkg::PH_CMD8: begin
          // a missing or wrong echo just means a v1 card
          v2_d       = !fail && (beat_i.response_word0[7:0] == sdci_pkg::CMD8_ECHO);
          phase_d    = sdci_pkg::PH_POLL;
          poll_cnt_d = '0;
          app_d      = 1'b0;
          issue      = 1'b1;
          idx        = sdci_pkg::CMD_APP;
          kind       = sdci_pkg::RK_R1;
        end
        sdci_pkg::PH_POLL: begin
          if (fail) begin
            phase_d = sdci_pkg::PH_ERR;
          end else if (!app_q) begin
            app_d = 1'b1;
            issue = 1'b1;
            idx   = sdci_pkg::ACMD_SD_SEND_OP;
            arg   = v2_q ? (sdci_pkg::ACMD41_HCS | sdci_pkg::ACMD41_VOLT)
                         : sdci_pkg::ACMD41_VOLT;
            kind  = sdci_pkg::RK_R3;
          end else begin
            app_d = 1'b0;
            if (beat_i.response_word0[sdci_pkg::OCR_BUSY_BIT]) begin
              hc_d    = beat_i.response_word0[sdci_pkg::OCR_CCS_BIT];
              phase_d = sdci_pkg::PH_CID;
              issue   = 1'b1;
              idx     = sdci_pkg::CMD_ALL_SEND_CID;
              kind    = sdci_pkg::RK_R2;
            end else begin
              poll_cnt_d = poll_inc;
              issue      = 1'b1;
              if (poll_inc < cfg_i.poll_limit) begin
                idx  = sdci_pkg::CMD_APP;
                kind = sdci_pkg::RK_R1;
              end else begin
                // out of rounds: carry on as standard capacity
                phase_d = sdci_pkg::PH_CID;
                idx     = sdci_pkg::CMD_ALL_SEND_CID;
                kind    = sdci_pkg::RK_R2;
              end
            end
          end
        end
        sdci_pkg::PH_CID: begin
          if (fail) begin
            phase_d = sdci_pkg::PH_ERR;
          end else begin
            phase_d = sdci_pkg::PH_RCA;
            issue   = 1'b1;
            idx     = sdci_pkg::CMD_SEND_RCA;
            kind    = sdci_pkg::RK_R6;
          end
        end
        sdci_pkg::PH_RCA: begin
          if (fail) begin
            phase_d = sdci_pkg::PH_ERR;
          end else begin
            rca_d   = beat_i.response_word0[31:16];
            phase_d = sdci_pkg::PH_CSD;
            issue   = 1'b1;
            idx     = sdci_pkg::CMD_SEND_CSD;
            arg     = {beat_i.response_word0[31:16], 16'd0};
            kind    = sdci_pkg::RK_R2;
          end
        end
        sdci_pkg::PH_CSD: begin
          if (fail) begin
            phase_d = sdci_pkg::PH_ERR;
          end else begin
            blocks_d = csd_blocks;
            phase_d  = sdci_pkg::PH_SEL;
            issue    = 1'b1;
            idx      = sdci_pkg::CMD_SELECT;
            arg      = {rca_q, 16'd0};
            kind     = sdci_pkg::RK_R1B;
          end
        end
        sdci_pkg::PH_SEL, sdci_pkg::PH_BLK: begin
          if (fail) begin
            phase_d = sdci_pkg::PH_ERR;
          end else if (phase_q == sdci_pkg::PH_SEL && !hc_q) begin
            phase_d = sdci_pkg::PH_BLK;
            issue   = 1'b1;
            idx     = sdci_pkg::CMD_SET_BLOCKLEN;
            arg     = sdci_pkg::BLOCKLEN_ARG;
            kind    = sdci_pkg::RK_R1;
          end else if (cfg_i.host_four_bit) begin
            phase_d = sdci_pkg::PH_BUS;
            app_d   = 1'b0;
            issue   = 1'b1;
            idx     = sdci_pkg::CMD_APP;
            arg     = {rca_q, 16'd0};
            kind    = sdci_pkg::RK_R1;
          end else begin
            phase_d = sdci_pkg::PH_DONE;
            sw      = 1'b1;
          end
        end
        sdci_pkg::PH_BUS: begin
          // failures here are tolerated, the bus just stays 1-bit
          if (!app_q && !fail) begin
            app_d = 1'b1;
            issue = 1'b1;
            idx   = sdci_pkg::ACMD_SET_BUS_WIDTH;
            arg   = sdci_pkg::BUS4_ARG;
            kind  = sdci_pkg::RK_R1;
          end else begin
            if (app_q && !fail) begin
              four_d = 1'b1;
            end
            app_d   = 1'b0;
            phase_d = sdci_pkg::PH_DONE;
            sw      = 1'b1;
          end
        end
        default: begin
          // idle, done and error ignore outcomes
        end
      endcase
    end
  end

  always_comb begin
    res_o.issue_cmd       = issue;
    res_o.cmd_index       = idx;
    res_o.cmd_argument    = arg;
    res_o.response_kind   = kind;
    res_o.phase           = phase_d;
    res_o.high_capacity   = hc_d;
    res_o.card_address    = rca_d;
    res_o.size_blocks     = blocks_d;
    res_o.bus_four_bit    = four_d;
    res_o.switch_clock    = sw;
    res_o.init_done       = (phase_d == sdci_pkg::PH_DONE);
    res_o.init_error      = (phase_d == sdci_pkg::PH_ERR);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= sdci_pkg::PH_IDLE;
      v2_q       <= 1'b0;
      poll_cnt_q <= '0;
      hc_q       <= 1'b0;
      rca_q      <= '0;
      blocks_q   <= '0;
      four_q     <= 1'b0;
      app_q      <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      v2_q       <= v2_d;
      poll_cnt_q <= poll_cnt_d;
      hc_q       <= hc_d;
      rca_q      <= rca_d;
      blocks_q   <= blocks_d;
      four_q     <= four_d;
      app_q      <= app_d;
    end
  end

endmodule

// ===== hdl/sd_card_init_sequencer_unit.sv =====
// SD card initialization sequencer, host side. A beat with operation 0 starts
// (or restarts) the bring-up and yields CMD0; every later beat carries the
// outcome of the last command and yields the next command (index, argument,
// expected response type) plus the card facts gathered so far: CMD8, CMD55/
// ACMD41 polling up to poll_limit rounds, CMD2, CMD3 (rca), CMD9 (capacity in
// 512-byte blocks), CMD7, CMD16 for standard capacity cards and CMD55/ACMD6
// when host_four_bit is set. Every input beat produces exactly one result beat.
// Throughput is one beat per clock while the receiver takes result beats; an
// accepted beat is held in the input register and its decision then lands in
// the result register. The rate is set by the phase decision, which reads the
// sequencer state and writes it back in the same cycle as it forms the result.
// Configuration is written through a plain write port and should only change
// while no beat is in flight.
module sd_card_init_sequencer_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  // command outcome beats
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sdci_pkg::in_beat_t  in_data_i,
  // next command beats
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sdci_pkg::out_beat_t out_data_o
);

  // configuration registers
  sdci_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.host_four_bit <= 1'b0;
      cfg_q.poll_limit    <= sdci_pkg::POLL_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sdci_pkg::CFG_IDX_HOST_FOUR_BIT: cfg_q.host_four_bit <= cfg_data_i[0];
        sdci_pkg::CFG_IDX_POLL_LIMIT:    cfg_q.poll_limit    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // input register
  logic               in_vld_q;
  sdci_pkg::in_beat_t in_q;
  // result register
  logic                out_vld_q;
  sdci_pkg::out_beat_t out_q;
  sdci_pkg::out_beat_t res;

  logic out_free;
  logic step;

  // the result slot frees up when it is empty or its beat leaves this cycle
  assign out_free   = !out_vld_q || out_ready_i;
  // a held beat is decided once it can land in the result register
  assign step       = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // phase decision and card state
  sdci_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .beat_i (in_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/sdci_checker.sv =====
module sdci_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input sdci_pkg::out_beat_t out_data_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // clock switch only on the beat that enters done
  a_switch_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.switch_clock |->
      out_data_o.init_done && out_data_o.phase == sdci_pkg::PH_DONE &&
      !out_data_o.issue_cmd)
    else $error("clock switch outside done");

  // terminal phases never issue a command
  a_final_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.init_done || out_data_o.init_error) |->
      !out_data_o.issue_cmd && !(out_data_o.init_done && out_data_o.init_error))
    else $error("command issued in done or error");

  // no command means empty command fields
  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.issue_cmd |->
      out_data_o.cmd_index == '0 && out_data_o.cmd_argument == '0 &&
      out_data_o.response_kind == sdci_pkg::RK_NONE)
    else $error("command fields set without a command");

endmodule

bind sd_card_init_sequencer_unit sdci_checker u_sdci_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ===== tb/sv/sdci_checker.sv =====
module sdci_tb_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  sdci_pkg::in_beat_t  in_data_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  sdci_pkg::out_beat_t out_data_i,
  output int         fail_count_o,
  output int         pending_o
);

  // configuration as last written
  logic        host4_cfg;
  logic [15:0] poll_lim_cfg;

  // sequencer state
  sdci_pkg::phase_e seq_ph;
  logic        is_v2;
  logic [15:0] poll_rounds;
  logic        is_hc;
  logic [15:0] card_rca;
  logic [32:0] card_blocks;
  logic        bus_wide;
  logic        acmd_next;

  sdci_pkg::out_beat_t predicted_cmds[$];
  int          mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic sdci_pkg::out_beat_t cmd_beat(logic [5:0] idx, logic [31:0] arg,
                                                   sdci_pkg::resp_kind_e kind);
    sdci_pkg::out_beat_t c;
    c = '0;
    c.issue_cmd     = 1'b1;
    c.cmd_index     = idx;
    c.cmd_argument  = arg;
    c.response_kind = kind;
    return c;
  endfunction

  function automatic sdci_pkg::out_beat_t next_command(sdci_pkg::in_beat_t b);
    sdci_pkg::out_beat_t r;
    logic       fatal;
    logic       to_bus;
    logic       to_cid;
    logic       sw;
    logic [7:0] c5, c6, c7, c8, c9, c10;
    logic [63:0] bytes;
    logic [31:0] op_arg;
    r      = '0;
    to_bus = 1'b0;
    to_cid = 1'b0;
    sw     = 1'b0;
    // csd bytes in little-endian word order
    {c7, c6, c5}  = b.response_word1[31:8];
    {c10, c9, c8} = b.response_word2[23:0];
    case (seq_ph)
      sdci_pkg::PH_CMD8, sdci_pkg::PH_BUS, sdci_pkg::PH_IDLE, sdci_pkg::PH_DONE,
      sdci_pkg::PH_ERR: fatal = 1'b0;
      default: fatal = b.cmd_failed;
    endcase
    if (b.operation == sdci_pkg::OP_START) begin
      is_v2       = 1'b0;
      poll_rounds = '0;
      is_hc       = 1'b0;
      card_rca    = '0;
      card_blocks = '0;
      bus_wide    = 1'b0;
      acmd_next   = 1'b0;
      seq_ph      = sdci_pkg::PH_CMD0;
      r = cmd_beat(sdci_pkg::CMD_GO_IDLE, '0, sdci_pkg::RK_NONE);
    end else if (fatal) begin
      seq_ph = sdci_pkg::PH_ERR;
    end else begin
      case (seq_ph)
        sdci_pkg::PH_CMD0: begin
          seq_ph = sdci_pkg::PH_CMD8;
          r = cmd_beat(sdci_pkg::CMD_SEND_IF_COND, sdci_pkg::CMD8_ARG, sdci_pkg::RK_R7);
        end
        sdci_pkg::PH_CMD8: begin
          is_v2       = !b.cmd_failed && (b.response_word0[7:0] == sdci_pkg::CMD8_ECHO);
          seq_ph      = sdci_pkg::PH_POLL;
          poll_rounds = '0;
          acmd_next   = 1'b0;
          r = cmd_beat(sdci_pkg::CMD_APP, '0, sdci_pkg::RK_R1);
        end
        sdci_pkg::PH_POLL: begin
          if (!acmd_next) begin
            acmd_next = 1'b1;
            op_arg = is_v2 ? (sdci_pkg::ACMD41_HCS | sdci_pkg::ACMD41_VOLT)
                           : sdci_pkg::ACMD41_VOLT;
            r = cmd_beat(sdci_pkg::ACMD_SD_SEND_OP, op_arg, sdci_pkg::RK_R3);
          end else begin
            acmd_next = 1'b0;
            if (b.response_word0[sdci_pkg::OCR_BUSY_BIT]) begin
              is_hc  = b.response_word0[sdci_pkg::OCR_CCS_BIT];
              to_cid = 1'b1;
            end else begin
              if (poll_rounds != 16'hFFFF) poll_rounds = poll_rounds + 16'd1;
              if (poll_rounds < poll_lim_cfg) begin
                r = cmd_beat(sdci_pkg::CMD_APP, '0, sdci_pkg::RK_R1);
              end else begin
                to_cid = 1'b1;
              end
            end
          end
          if (to_cid) begin
            seq_ph = sdci_pkg::PH_CID;
            r = cmd_beat(sdci_pkg::CMD_ALL_SEND_CID, '0, sdci_pkg::RK_R2);
          end
        end
        sdci_pkg::PH_CID: begin
          seq_ph = sdci_pkg::PH_RCA;
          r = cmd_beat(sdci_pkg::CMD_SEND_RCA, '0, sdci_pkg::RK_R6);
        end
        sdci_pkg::PH_RCA: begin
          card_rca = b.response_word0[31:16];
          seq_ph   = sdci_pkg::PH_CSD;
          r = cmd_beat(sdci_pkg::CMD_SEND_CSD, {card_rca, 16'h0000}, sdci_pkg::RK_R2);
        end
        sdci_pkg::PH_CSD: begin
          if (is_hc) begin
            bytes = (64'({c7[5:0], c8, c9}) + 64'd1) << 10;
          end else begin
            bytes = (64'({c6[1:0], c7, c8[7:6]}) + 64'd1)
                    << (32'({c9[1:0], c10[7]}) + 32'd2 + 32'(c5[3:0]));
            bytes = bytes >> 9;
          end
          card_blocks = bytes[32:0];
          seq_ph      = sdci_pkg::PH_SEL;
          r = cmd_beat(sdci_pkg::CMD_SELECT, {card_rca, 16'h0000}, sdci_pkg::RK_R1B);
        end
        sdci_pkg::PH_SEL: begin
          if (!is_hc) begin
            seq_ph = sdci_pkg::PH_BLK;
            r = cmd_beat(sdci_pkg::CMD_SET_BLOCKLEN, sdci_pkg::BLOCKLEN_ARG,
                         sdci_pkg::RK_R1);
          end else begin
            to_bus = 1'b1;
          end
        end
        sdci_pkg::PH_BLK: to_bus = 1'b1;
        sdci_pkg::PH_BUS: begin
          if (!acmd_next && !b.cmd_failed) begin
            acmd_next = 1'b1;
            r = cmd_beat(sdci_pkg::ACMD_SET_BUS_WIDTH, sdci_pkg::BUS4_ARG,
                         sdci_pkg::RK_R1);
          end else begin
            if (acmd_next && !b.cmd_failed) bus_wide = 1'b1;
            acmd_next = 1'b0;
            seq_ph    = sdci_pkg::PH_DONE;
            sw        = 1'b1;
          end
        end
        default: ;
      endcase
      if (to_bus) begin
        if (host4_cfg) begin
          seq_ph    = sdci_pkg::PH_BUS;
          acmd_next = 1'b0;
          r = cmd_beat(sdci_pkg::CMD_APP, {card_rca, 16'h0000}, sdci_pkg::RK_R1);
        end else begin
          seq_ph = sdci_pkg::PH_DONE;
          sw     = 1'b1;
        end
      end
    end
    r.phase           = seq_ph;
    r.high_capacity   = is_hc;
    r.card_address    = card_rca;
    r.size_blocks     = card_blocks;
    r.bus_four_bit    = bus_wide;
    r.switch_clock    = sw;
    r.init_done       = (seq_ph == sdci_pkg::PH_DONE);
    r.init_error      = (seq_ph == sdci_pkg::PH_ERR);
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (got_v !== exp_v) begin
      mismatches++;
      $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    sdci_pkg::out_beat_t want;
    if (!rst_ni) begin
      host4_cfg    = 1'b0;
      poll_lim_cfg = sdci_pkg::POLL_LIMIT_RST;
      seq_ph       = sdci_pkg::PH_IDLE;
      is_v2        = 1'b0;
      poll_rounds  = '0;
      is_hc        = 1'b0;
      card_rca     = '0;
      card_blocks  = '0;
      bus_wide     = 1'b0;
      acmd_next    = 1'b0;
      predicted_cmds.delete();
      pending_o <= 0;
    end else begin
      // compare first: a beat leaving now never belongs to one entering now
      if (out_valid_i && out_ready_i) begin
        if (predicted_cmds.size() == 0) begin
          mismatches++;
          $display("%0t: result beat expected none got 0x%0h", $time, out_data_i);
        end else begin
          want = predicted_cmds.pop_front();
          check_field("issue_cmd", 64'(want.issue_cmd), 64'(out_data_i.issue_cmd));
          check_field("cmd_index", 64'(want.cmd_index), 64'(out_data_i.cmd_index));
          check_field("cmd_argument", 64'(want.cmd_argument),
                      64'(out_data_i.cmd_argument));
          check_field("response_kind", 64'(want.response_kind),
                      64'(out_data_i.response_kind));
          check_field("phase", 64'(want.phase), 64'(out_data_i.phase));
          check_field("high_capacity", 64'(want.high_capacity),
                      64'(out_data_i.high_capacity));
          check_field("card_address", 64'(want.card_address),
                      64'(out_data_i.card_address));
          check_field("size_blocks", 64'(want.size_blocks),
                      64'(out_data_i.size_blocks));
          check_field("bus_four_bit", 64'(want.bus_four_bit),
                      64'(out_data_i.bus_four_bit));
          check_field("switch_clock", 64'(want.switch_clock),
                      64'(out_data_i.switch_clock));
          check_field("init_done", 64'(want.init_done), 64'(out_data_i.init_done));
          check_field("init_error", 64'(want.init_error), 64'(out_data_i.init_error));
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == sdci_pkg::CFG_IDX_HOST_FOUR_BIT) host4_cfg = cfg_data_i[0];
        else if (cfg_idx_i == sdci_pkg::CFG_IDX_POLL_LIMIT) poll_lim_cfg = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) predicted_cmds.push_back(next_command(in_data_i));
      pending_o <= predicted_cmds.size();
    end
  end

endmodule

// ===== tb/sv/tb_sd_card_init_sequencer_unit.sv =====
module tb_sd_card_init_sequencer_unit;

  localparam int ITEM_TARGET   = 1850;
  localparam int CYCLE_LIMIT   = 600000;
  // input register plus result register, with some slack
  localparam int SETTLE_CYCLES = 4;

  // receiver back-pressure styles
  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_HALF,
    RDY_SPARSE,
    RDY_PATTERN
  } rdy_mode_e;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        cfg_we_i   = 1'b0;
  logic        cfg_idx_i  = sdci_pkg::CFG_IDX_HOST_FOUR_BIT;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  sdci_pkg::in_beat_t  in_data_i  = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  sdci_pkg::out_beat_t out_data_o;

  int          fail_count;
  int          pending_cmds;
  int          cycles      = 0;
  int          beats_sent  = 0;
  int          burst_left  = 0;
  // stimulus-side copy of the settings, used only to shape bring-up sessions
  logic        host4_sel    = 1'b0;
  int          poll_lim_sel = 1000;
  rdy_mode_e   rdy_mode     = RDY_ALWAYS;
  int          rdy_tick     = 0;

  always #5 clk_i = ~clk_i;

  sd_card_init_sequencer_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // watches both channels and the config port, predicts and compares
  sdci_tb_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .fail_count_o (fail_count),
    .pending_o    (pending_cmds)
  );

  // run watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_sd_card_init_sequencer_unit NOT OK");
      $finish;
    end
  end

  // receiver: switches between random stall styles, one style never stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      rdy_tick <= rdy_tick + 1;
      if (rdy_tick % 97 == 0) rdy_mode <= rdy_mode_e'($urandom_range(0, 3));
      case (rdy_mode)
        RDY_ALWAYS: out_ready_i <= 1'b1;
        RDY_HALF:   out_ready_i <= 1'($urandom_range(0, 1));
        RDY_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
        default:    out_ready_i <= ((rdy_tick % 8) < 5);
      endcase
    end
  end

  function automatic logic coin(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // one beat into the block; bursts of random length, random gaps between them
  task automatic push_beat(input sdci_pkg::in_beat_t b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    burst_left--;
    beats_sent++;
  endtask

  task automatic send_start();
    sdci_pkg::in_beat_t b;
    b.operation      = sdci_pkg::OP_START;
    b.cmd_failed     = 1'($urandom);
    b.response_word0 = $urandom;
    b.response_word1 = $urandom;
    b.response_word2 = $urandom;
    push_beat(b);
  endtask

  task automatic send_outcome(input logic failed, input logic [31:0] w0,
                              input logic [31:0] w1, input logic [31:0] w2);
    sdci_pkg::in_beat_t b;
    b.operation      = sdci_pkg::OP_OUTCOME;
    b.cmd_failed     = failed;
    b.response_word0 = w0;
    b.response_word1 = w1;
    b.response_word2 = w2;
    push_beat(b);
  endtask

  // hold off the sender until every predicted command has come out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_cmds != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    burst_left = 0;
  endtask

  // only called with the block drained
  task automatic program_cfg(input logic h4, input logic [15:0] lim);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sdci_pkg::CFG_IDX_HOST_FOUR_BIT;
    cfg_data_i <= {15'd0, h4};
    @(posedge clk_i);
    cfg_idx_i  <= sdci_pkg::CFG_IDX_POLL_LIMIT;
    cfg_data_i <= lim;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    host4_sel    = h4;
    poll_lim_sel = lim;
  endtask

  // well-formed bring-up with random response content; a fatal failure ends it
  task automatic bring_up_card(input int fail_pct);
    logic        f;
    logic        hc;
    logic        exhaust;
    logic [31:0] w0;
    int          lim_eff;
    int          rounds;
    hc = 1'b0;
    send_start();
    // go idle
    f = coin(fail_pct);
    send_outcome(f, $urandom, $urandom, $urandom);
    if (f) return;
    // interface condition: echo mostly right, sometimes wrong or failed
    w0 = $urandom;
    if (!coin(20)) w0[7:0] = sdci_pkg::CMD8_ECHO;
    send_outcome(coin(15), w0, $urandom, $urandom);
    // op-cond polling, now and then until the round limit runs out
    lim_eff = (poll_lim_sel == 0) ? 1 : poll_lim_sel;
    exhaust = (lim_eff <= 6) && coin(30);
    rounds  = exhaust ? lim_eff : $urandom_range(0, (lim_eff - 1 < 4) ? lim_eff - 1 : 4);
    for (int i = 0; i < rounds + (exhaust ? 0 : 1); i++) begin
      f = coin(fail_pct);
      send_outcome(f, $urandom, $urandom, $urandom);
      if (f) return;
      w0 = $urandom;
      w0[sdci_pkg::OCR_BUSY_BIT] = (i == rounds);
      f = coin(fail_pct);
      send_outcome(f, w0, $urandom, $urandom);
      if (f) return;
      if (i == rounds) hc = w0[sdci_pkg::OCR_CCS_BIT];
    end
    // cid, rca, csd, select: all fatal on failure, random payloads
    repeat (4) begin
      f = coin(fail_pct);
      send_outcome(f, $urandom, $urandom, $urandom);
      if (f) return;
    end
    // block length for standard capacity only
    if (!hc) begin
      f = coin(fail_pct);
      send_outcome(f, $urandom, $urandom, $urandom);
      if (f) return;
    end
    // bus width: failures tolerated on either beat
    if (host4_sel) begin
      f = coin(20);
      send_outcome(f, $urandom, $urandom, $urandom);
      if (!f) send_outcome(coin(20), $urandom, $urandom, $urandom);
    end
    // stray outcome after done, must be ignored
    if (coin(10)) send_outcome(1'($urandom), $urandom, $urandom, $urandom);
  endtask

  // unstructured beats, including restarts
  task automatic send_noise();
    sdci_pkg::in_beat_t b;
    repeat ($urandom_range(1, 6)) begin
      b.operation      = coin(20) ? sdci_pkg::OP_START : sdci_pkg::OP_OUTCOME;
      b.cmd_failed     = 1'($urandom);
      b.response_word0 = $urandom;
      b.response_word1 = $urandom;
      b.response_word2 = $urandom;
      push_beat(b);
    end
  endtask

  initial begin
    int fail_pct;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset settings: outcome while idle is ignored
    send_outcome(1'b1, '1, '1, '1);
    // clean high capacity bring-up, all-ones csd gives the largest capacity
    send_start();
    send_outcome(1'b0, '0, '0, '0);
    send_outcome(1'b0, sdci_pkg::CMD8_ARG, '1, '1);
    send_outcome(1'b0, '0, '0, '0);
    send_outcome(1'b0, '0, '1, '1);
    send_outcome(1'b0, '0, '0, '0);
    send_outcome(1'b0, '1, '0, '0);
    send_outcome(1'b0, '0, '0, '0);
    send_outcome(1'b0, '1, '0, '0);
    send_outcome(1'b0, '0, '1, '1);
    send_outcome(1'b0, '0, '0, '0);
    // outcome while done is ignored
    send_outcome(1'b0, '1, '1, '1);
    // go idle fails, then outcome while in error
    send_start();
    send_outcome(1'b1, '0, '0, '0);
    send_outcome(1'b0, '1, '1, '1);
    // failed interface condition is tolerated, then restart mid-polling
    send_start();
    send_outcome(1'b0, '0, '0, '0);
    send_outcome(1'b1, sdci_pkg::CMD8_ARG, '0, '0);
    send_outcome(1'b0, '0, '0, '0);
    send_start();

    // random phases, each under its own settings; extremes first
    for (int ph = 0; beats_sent < ITEM_TARGET; ph++) begin
      drain_results();
      case (ph)
        0: program_cfg(1'b1, 16'd0);
        1: program_cfg(1'b0, 16'd1);
        2: program_cfg(1'b1, 16'hFFFF);
        3: program_cfg(1'b0, 16'd2);
        4: program_cfg(1'b1, sdci_pkg::POLL_LIMIT_RST);
        default: program_cfg(1'($urandom), coin(15) ? 16'($urandom_range(1, 65535))
                                                    : 16'($urandom_range(1, 6)));
      endcase
      fail_pct = $urandom_range(0, 6);
      repeat (12) begin
        if (coin(15)) send_noise();
        else bring_up_card(fail_pct);
        // occasional full pause of the sender mid-phase
        if (coin(8)) drain_results();
      end
    end

    drain_results();
    if (fail_count == 0) begin
      $display("tb_sd_card_init_sequencer_unit OK");
    end else begin
      $display("tb_sd_card_init_sequencer_unit NOT OK");
    end
    $finish;
  end

endmodule
